>>> sv/two_register_stack_cpu_core_assert.svh
// assertion macros for the two register stack cpu core
`ifndef TWO_REGISTER_STACK_CPU_CORE_ASSERT_SVH
`define TWO_REGISTER_STACK_CPU_CORE_ASSERT_SVH

// checked only while out of reset
`define TSC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define TSC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/tsc_pkg.sv
// package with constants, opcodes and types of the two register stack cpu core
`timescale 1ns / 1ps

package tsc_pkg;

    localparam int MEM_WORDS = 4096;
    localparam int ADDR_W    = $clog2(MEM_WORDS);
    localparam int WORD_W    = 32;

    localparam logic [WORD_W-1:0] SP_RESET = 32'h00FF_FFFF;

    typedef enum logic [1:0] {
        KIND_LOAD = 2'd0,
        KIND_EXEC = 2'd1,
        KIND_READ = 2'd2
    } kind_e;

    typedef enum logic [7:0] {
        OP_LDC    = 8'd0,
        OP_ADC    = 8'd1,
        OP_LDL    = 8'd2,
        OP_STL    = 8'd3,
        OP_LDNL   = 8'd4,
        OP_STNL   = 8'd5,
        OP_ADD    = 8'd6,
        OP_SUB    = 8'd7,
        OP_SHL    = 8'd8,
        OP_SHR    = 8'd9,
        OP_ADJ    = 8'd10,
        OP_A2SP   = 8'd11,
        OP_SP2A   = 8'd12,
        OP_CALL   = 8'd13,
        OP_RETURN = 8'd14,
        OP_BRZ    = 8'd15,
        OP_BRLZ   = 8'd16,
        OP_BR     = 8'd17,
        OP_HALT   = 8'd18
    } opcode_e;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_SHL,
        ALU_SAR
    } alu_op_e;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_DECODE,
        S_EXEC,
        S_WBACK
    } state_e;

endpackage

>>> sv/two_register_stack_cpu_core.sv
// load word and idle items are answered from idle, read word passes the read state,
// execute passes decode and exec, ldl and ldnl add write back; a halted core answers
// execute from idle; one item at a time, set by the single port word memory and one alu
// a new start is taken in the cycle the done strobe shows; the receiver cannot stall
// reset (rst_n low, asynchronous) clears a, b, pc and halted, sets sp to 0x00ffffff
// memory contents are not cleared by reset
`timescale 1ns / 1ps
`include "two_register_stack_cpu_core_assert.svh"

module two_register_stack_cpu_core
    import tsc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [1:0]               kind,
    input  logic [11:0]              address,
    input  logic [31:0]              data,
    output logic                     busy,
    output logic                     done,
    output logic signed [31:0]       acc_a,
    output logic signed [31:0]       acc_b,
    output logic [31:0]              stack_ptr,
    output logic [31:0]              prog_counter,
    output logic [31:0]              read_word,
    output logic                     halted
);

    state_e state_reg, state_next;

    logic [WORD_W-1:0] a_reg, a_next;
    logic [WORD_W-1:0] b_reg, b_next;
    logic [WORD_W-1:0] sp_reg, sp_next;
    logic [WORD_W-1:0] pc_reg, pc_next;
    logic              stopped_reg, stopped_next;
    logic              done_reg, done_next;
    logic [WORD_W-1:0] read_word_reg, read_word_next;
    logic [WORD_W-1:0] ir_reg, ir_next;

    logic [WORD_W-1:0] mem [MEM_WORDS];
    logic [WORD_W-1:0] rdata_reg;
    logic [ADDR_W-1:0] mem_addr;
    logic              mem_we;
    logic [WORD_W-1:0] mem_wdata;

    logic [WORD_W-1:0] alu_x, alu_y, alu_res;
    alu_op_e           alu_op;

    logic              accept;
    logic [WORD_W-1:0] operand;
    logic [7:0]        opcode;

    assign accept  = start && !busy;
    assign opcode  = ir_reg[7:0];
    assign operand = {{8{ir_reg[31]}}, ir_reg[31:8]};

    // shared alu
    always_comb
    begin
        case (alu_op)
            ALU_ADD: alu_res = alu_x + alu_y;
            ALU_SUB: alu_res = alu_x - alu_y;
            ALU_SHL: alu_res = (alu_y[31:5] != '0) ? '0 : (alu_x << alu_y[4:0]);
            ALU_SAR: alu_res = (alu_y[31:5] != '0) ? {WORD_W{alu_x[31]}}
                                                   : WORD_W'($signed(alu_x) >>> alu_y[4:0]);
            default: alu_res = alu_x + alu_y;
        endcase
    end

    // alu operand selection
    always_comb
    begin
        alu_x  = pc_reg;
        alu_y  = WORD_W'(1);
        alu_op = ALU_ADD;
        if (state_reg == S_EXEC)
        begin
            alu_y = operand;
            unique case (opcode)
                OP_ADC, OP_LDNL, OP_STNL: alu_x = a_reg;
                OP_LDL, OP_STL, OP_ADJ:   alu_x = sp_reg;
                OP_ADD:
                begin
                    alu_x = b_reg;
                    alu_y = a_reg;
                end
                OP_SUB:
                begin
                    alu_x  = b_reg;
                    alu_y  = a_reg;
                    alu_op = ALU_SUB;
                end
                OP_SHL:
                begin
                    alu_x  = b_reg;
                    alu_y  = a_reg;
                    alu_op = ALU_SHL;
                end
                OP_SHR:
                begin
                    alu_x  = b_reg;
                    alu_y  = a_reg;
                    alu_op = ALU_SAR;
                end
                default: alu_x = pc_reg;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (kind == KIND_READ)
                        state_next = S_READ;
                    else if (kind == KIND_EXEC && !stopped_reg)
                        state_next = S_DECODE;
                end
            end
            S_READ:   state_next = S_IDLE;
            S_DECODE: state_next = S_EXEC;
            S_EXEC:
            begin
                if (opcode == OP_LDL || opcode == OP_LDNL)
                    state_next = S_WBACK;
                else
                    state_next = S_IDLE;
            end
            S_WBACK:  state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        a_next         = a_reg;
        b_next         = b_reg;
        sp_next        = sp_reg;
        pc_next        = pc_reg;
        stopped_next   = stopped_reg;
        ir_next        = ir_reg;
        done_next      = 1'b0;
        read_word_next = read_word_reg;
        mem_addr       = ADDR_W'(address);
        mem_we         = 1'b0;
        mem_wdata      = data;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    read_word_next = '0;
                    if (kind == KIND_LOAD)
                    begin
                        mem_we    = 1'b1;
                        done_next = 1'b1;
                    end
                    else if (kind == KIND_EXEC && !stopped_reg)
                        mem_addr = pc_reg[ADDR_W-1:0];
                    else if (kind != KIND_READ)
                        done_next = 1'b1;
                end
            end
            S_READ:
            begin
                read_word_next = rdata_reg;
                done_next      = 1'b1;
            end
            S_DECODE:
            begin
                ir_next = rdata_reg;
                pc_next = alu_res;
            end
            S_EXEC:
            begin
                mem_addr  = alu_res[ADDR_W-1:0];
                done_next = !(opcode == OP_LDL || opcode == OP_LDNL);
                unique case (opcode)
                    OP_LDC:
                    begin
                        b_next = a_reg;
                        a_next = operand;
                    end
                    OP_LDL:  b_next = a_reg;
                    OP_STL:
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = a_reg;
                        a_next    = b_reg;
                    end
                    OP_STNL:
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = b_reg;
                    end
                    OP_ADC, OP_ADD, OP_SUB, OP_SHL, OP_SHR: a_next = alu_res;
                    OP_ADJ:  sp_next = alu_res;
                    OP_A2SP:
                    begin
                        sp_next = a_reg;
                        a_next  = b_reg;
                    end
                    OP_SP2A:
                    begin
                        b_next = a_reg;
                        a_next = sp_reg;
                    end
                    OP_CALL:
                    begin
                        b_next  = a_reg;
                        a_next  = pc_reg;
                        pc_next = alu_res;
                    end
                    OP_RETURN:
                    begin
                        pc_next = a_reg;
                        a_next  = b_reg;
                    end
                    OP_BRZ:
                    begin
                        if (a_reg == '0)
                            pc_next = alu_res;
                    end
                    OP_BRLZ:
                    begin
                        if (a_reg[31])
                            pc_next = alu_res;
                    end
                    OP_BR:   pc_next = alu_res;
                    OP_HALT: stopped_next = 1'b1;
                    default: ;
                endcase
            end
            S_WBACK:
            begin
                a_next    = rdata_reg;
                done_next = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            a_reg       <= '0;
            b_reg       <= '0;
            sp_reg      <= SP_RESET;
            pc_reg      <= '0;
            stopped_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            a_reg       <= a_next;
            b_reg       <= b_next;
            sp_reg      <= sp_next;
            pc_reg      <= pc_next;
            stopped_reg <= stopped_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ir_reg        <= ir_next;
        read_word_reg <= read_word_next;
    end

    // single port word memory, read before write
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        rdata_reg <= mem[mem_addr];
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign acc_a        = $signed(a_reg);
    assign acc_b        = $signed(b_reg);
    assign stack_ptr    = sp_reg;
    assign prog_counter = pc_reg;
    assign read_word    = read_word_reg;
    assign halted       = stopped_reg;

    `TSC_ASSERT(a_done_idle, done |-> !busy, "done strobe while the core is busy")
    `TSC_ASSERT(a_accept_busy, (accept && (kind == KIND_READ)) |=> busy, "read transfer not taken")
    `TSC_ASSERT(a_halt_sticky, halted |=> (halted && $stable(pc_reg)), "halted core changed pc")
    `TSC_ASSERT_ALWAYS(a_idle_in_reset, !rst_n |-> (!busy && !done), "core active in reset")

endmodule
